// File: hdl/dcs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcs_pkg
// Shared widths, codes and defaults of the discord candidate selection unit.
// ----------------------------------------------------------------------------
package dcs_pkg;

    localparam int DEF_MAX_CANDIDATES = 32;
    localparam int DEF_MAX_WINDOW     = 64;

    localparam int SAMPLE_W = 16;
    localparam int DIST_W   = 40;
    localparam int IDX_W    = 24;
    localparam int TOTAL_W  = 6;
    localparam int KIND_W   = 3;
    localparam int WLEN_W   = 7;
    localparam int SQ_W     = 2 * (SAMPLE_W + 1);

    localparam logic [DIST_W-1:0] DIST_MAX   = {DIST_W{1'b1}};
    localparam logic [WLEN_W-1:0] WLEN_RESET = WLEN_W'(64);

    typedef enum logic [0:0] {
        REG_THRESHOLD = 1'b0,
        REG_WINDOW    = 1'b1
    } cfg_reg_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_ACCEPTED = 3'd0,
        KIND_REJECTED = 3'd1,
        KIND_OVERFLOW = 3'd2,
        KIND_LISTED   = 3'd3,
        KIND_EMPTY    = 3'd4
    } result_kind_t;

endpackage

// File: hdl/discord_candidate_selection_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// discord_candidate_selection_unit
// Candidate table of a discord search: one sample per request, a comparison
// pass over the stored candidates when a subsequence completes, and readout.
// ----------------------------------------------------------------------------
// A sample that does not complete a subsequence gives no result. A completing
// sample walks every slot below the high-water mark, accumulates window_length
// sample pairs per compared slot (one sample pair per cycle from the sample
// memories), and copies MAX_WINDOW samples into the table when stored.
// Readout walks every slot below the high-water mark.
// Results cannot be stalled. Reset clears the table and all control state.
module discord_candidate_selection_unit #(
    parameter int MAX_CANDIDATES = dcs_pkg::DEF_MAX_CANDIDATES,
    parameter int MAX_WINDOW     = dcs_pkg::DEF_MAX_WINDOW
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              mode,
    input  logic signed [dcs_pkg::SAMPLE_W-1:0] sample_value,
    input  logic                              cfg_write,
    input  logic                              cfg_index,
    input  logic [dcs_pkg::DIST_W-1:0]        cfg_data,
    output logic                              done,
    output logic [dcs_pkg::KIND_W-1:0]        result_kind,
    output logic [dcs_pkg::IDX_W-1:0]         candidate_index,
    output logic [dcs_pkg::TOTAL_W-1:0]       candidate_total,
    output logic                              last_result
);

    localparam int SW  = $clog2(MAX_CANDIDATES);
    localparam int HW  = $clog2(MAX_CANDIDATES + 1);
    localparam int PW  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int WLW = $clog2(MAX_WINDOW + 1);
    localparam int AW  = $clog2(MAX_CANDIDATES * MAX_WINDOW);

    typedef enum logic [3:0] {
        ST_IDLE, ST_SLOT, ST_GAP, ST_ACC, ST_WAIT, ST_CMP, ST_DECIDE,
        ST_COPY, ST_CPEND, ST_LRD, ST_LOUT, ST_LFIN
    } state_t;

    state_t                          state_reg, state_next;
    logic [dcs_pkg::DIST_W-1:0]      thr_reg, thr_next;
    logic [dcs_pkg::WLEN_W-1:0]      wl_reg, wl_next;
    logic [MAX_CANDIDATES-1:0]       valid_reg, valid_next;
    logic [SW-1:0]                   fsp_reg, fsp_next;
    logic [HW-1:0]                   hwm_reg, hwm_next;
    logic [HW-1:0]                   cnt_reg, cnt_next;
    logic [dcs_pkg::IDX_W-1:0]       ctr_reg, ctr_next;
    logic [PW-1:0]                   pos_reg, pos_next;
    logic [SW-1:0]                   j_reg, j_next;
    logic [PW-1:0]                   k_reg, k_next;
    logic                            matched_reg, matched_next;
    logic [dcs_pkg::DIST_W-1:0]      acc_reg, acc_next;
    logic [dcs_pkg::SQ_W-1:0]        sq_reg, sq_next;
    logic                            s1_vld_reg, s1_vld_next;
    logic                            s1_last_reg, s1_last_next;
    logic                            s2_vld_reg, s2_vld_next;
    logic                            s2_last_reg, s2_last_next;
    logic [SW-1:0]                   dst_reg, dst_next;
    logic                            cpw_reg, cpw_next;
    logic [PW-1:0]                   cpk_reg, cpk_next;
    logic                            pend_reg, pend_next;
    logic [dcs_pkg::IDX_W-1:0]       pend_idx_reg, pend_idx_next;
    logic                            done_reg, done_next;
    dcs_pkg::result_kind_t           kind_reg, kind_next;
    logic [dcs_pkg::IDX_W-1:0]       idx_reg, idx_next;
    logic [HW-1:0]                   total_reg, total_next;
    logic                            last_reg, last_next;

    logic signed [dcs_pkg::SAMPLE_W-1:0] win_mem [MAX_WINDOW];
    logic signed [dcs_pkg::SAMPLE_W-1:0] cand_mem [MAX_CANDIDATES * MAX_WINDOW];
    logic [dcs_pkg::IDX_W-1:0]           start_mem [MAX_CANDIDATES];
    logic signed [dcs_pkg::SAMPLE_W-1:0] win_q, cand_q;
    logic [dcs_pkg::IDX_W-1:0]           start_q;

    logic                            accept, win_we, start_we;
    logic [SW-1:0]                   start_waddr;
    logic [AW-1:0]                   cand_raddr, cand_waddr;
    logic [WLW-1:0]                  wl_eff;
    logic                            pos_more, k_last, cp_last, last_slot, far;
    logic signed [dcs_pkg::SAMPLE_W:0]   diff;
    logic signed [dcs_pkg::SQ_W-1:0]     prod;
    logic [dcs_pkg::DIST_W:0]        sum;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    always_comb
    begin
        if (wl_reg == '0)
        begin
            wl_eff = WLW'(1);
        end
        else if (32'(wl_reg) > 32'(MAX_WINDOW))
        begin
            wl_eff = WLW'(MAX_WINDOW);
        end
        else
        begin
            wl_eff = WLW'(wl_reg);
        end
    end

    assign pos_more  = (32'(pos_reg) + 32'd1) < 32'(wl_eff);
    assign k_last    = (32'(k_reg) + 32'd1) == 32'(wl_eff);
    assign cp_last   = 32'(k_reg) == 32'(MAX_WINDOW - 1);
    assign last_slot = (32'(j_reg) + 32'd1) >= 32'(hwm_reg);
    assign far       = (ctr_reg - start_q) >= dcs_pkg::IDX_W'(wl_eff);

    assign cand_raddr = AW'(32'(j_reg) * MAX_WINDOW) + AW'(k_reg);
    assign cand_waddr = AW'(32'(dst_reg) * MAX_WINDOW) + AW'(cpk_reg);

    assign diff = {win_q[dcs_pkg::SAMPLE_W-1], win_q} - {cand_q[dcs_pkg::SAMPLE_W-1], cand_q};
    assign prod = diff * diff;
    assign sum  = {1'b0, acc_reg} + (dcs_pkg::DIST_W + 1)'(sq_reg);

    always_comb
    begin
        state_next    = state_reg;
        thr_next      = thr_reg;
        wl_next       = wl_reg;
        valid_next    = valid_reg;
        fsp_next      = fsp_reg;
        hwm_next      = hwm_reg;
        cnt_next      = cnt_reg;
        ctr_next      = ctr_reg;
        pos_next      = pos_reg;
        j_next        = j_reg;
        k_next        = k_reg;
        matched_next  = matched_reg;
        acc_next      = acc_reg;
        sq_next       = $unsigned(prod);
        s1_vld_next   = 1'b0;
        s1_last_next  = 1'b0;
        s2_vld_next   = s1_vld_reg;
        s2_last_next  = s1_last_reg;
        dst_next      = dst_reg;
        cpw_next      = 1'b0;
        cpk_next      = k_reg;
        pend_next     = pend_reg;
        pend_idx_next = pend_idx_reg;
        done_next     = 1'b0;
        kind_next     = kind_reg;
        idx_next      = idx_reg;
        total_next    = total_reg;
        last_next     = last_reg;
        win_we        = 1'b0;
        start_we      = 1'b0;
        start_waddr   = dst_reg;

        if (cfg_write)
        begin
            unique case (cfg_index)
                dcs_pkg::REG_THRESHOLD: thr_next = cfg_data;
                dcs_pkg::REG_WINDOW:    wl_next  = cfg_data[dcs_pkg::WLEN_W-1:0];
                default:                thr_next = thr_reg;
            endcase
        end

        if (s2_vld_reg)
        begin
            acc_next = sum[dcs_pkg::DIST_W] ? dcs_pkg::DIST_MAX : sum[dcs_pkg::DIST_W-1:0];
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    j_next = '0;
                    if (mode)
                    begin
                        pend_next  = 1'b0;
                        state_next = ST_LRD;
                    end
                    else
                    begin
                        win_we = 1'b1;
                        if (pos_more)
                        begin
                            pos_next = pos_reg + PW'(1);
                        end
                        else
                        begin
                            pos_next     = '0;
                            matched_next = 1'b0;
                            state_next   = ST_SLOT;
                        end
                    end
                end
            end
            ST_SLOT:
            begin
                state_next = ST_GAP;
            end
            ST_GAP:
            begin
                acc_next = '0;
                k_next   = '0;
                if (valid_reg[j_reg] && far)
                begin
                    state_next = ST_ACC;
                end
                else if (last_slot)
                begin
                    state_next = ST_DECIDE;
                end
                else
                begin
                    j_next     = j_reg + SW'(1);
                    state_next = ST_SLOT;
                end
            end
            ST_ACC:
            begin
                s1_vld_next  = 1'b1;
                s1_last_next = k_last;
                k_next       = k_reg + PW'(1);
                if (k_last)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (s2_vld_reg && s2_last_reg)
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                if (acc_reg < thr_reg)
                begin
                    matched_next      = 1'b1;
                    valid_next[j_reg] = 1'b0;
                    fsp_next          = j_reg;
                    cnt_next          = cnt_reg - HW'(1);
                end
                if (last_slot)
                begin
                    state_next = ST_DECIDE;
                end
                else
                begin
                    j_next     = j_reg + SW'(1);
                    state_next = ST_SLOT;
                end
            end
            ST_DECIDE:
            begin
                done_next  = 1'b1;
                idx_next   = ctr_reg;
                last_next  = 1'b1;
                total_next = cnt_reg;
                ctr_next   = ctr_reg + dcs_pkg::IDX_W'(1);
                state_next = ST_IDLE;
                if (matched_reg)
                begin
                    kind_next = dcs_pkg::KIND_REJECTED;
                end
                else if (!valid_reg[fsp_reg] || (32'(hwm_reg) < 32'(MAX_CANDIDATES)))
                begin
                    if (!valid_reg[fsp_reg])
                    begin
                        start_waddr = fsp_reg;
                    end
                    else
                    begin
                        start_waddr = hwm_reg[SW-1:0];
                        hwm_next    = hwm_reg + HW'(1);
                    end
                    dst_next                = start_waddr;
                    start_we                = 1'b1;
                    valid_next[start_waddr] = 1'b1;
                    cnt_next                = cnt_reg + HW'(1);
                    total_next              = cnt_reg + HW'(1);
                    kind_next               = dcs_pkg::KIND_ACCEPTED;
                    k_next                  = '0;
                    state_next              = ST_COPY;
                end
                else
                begin
                    kind_next = dcs_pkg::KIND_OVERFLOW;
                end
            end
            ST_COPY:
            begin
                cpw_next = 1'b1;
                k_next   = k_reg + PW'(1);
                if (cp_last)
                begin
                    state_next = ST_CPEND;
                end
            end
            ST_CPEND:
            begin
                state_next = ST_IDLE;
            end
            ST_LRD:
            begin
                state_next = ST_LOUT;
            end
            ST_LOUT:
            begin
                if (valid_reg[j_reg])
                begin
                    if (pend_reg)
                    begin
                        done_next  = 1'b1;
                        kind_next  = dcs_pkg::KIND_LISTED;
                        idx_next   = pend_idx_reg;
                        total_next = cnt_reg;
                        last_next  = 1'b0;
                    end
                    pend_next     = 1'b1;
                    pend_idx_next = start_q;
                end
                if (last_slot)
                begin
                    state_next = ST_LFIN;
                end
                else
                begin
                    j_next     = j_reg + SW'(1);
                    state_next = ST_LRD;
                end
            end
            ST_LFIN:
            begin
                done_next  = 1'b1;
                last_next  = 1'b1;
                pend_next  = 1'b0;
                state_next = ST_IDLE;
                if (pend_reg)
                begin
                    kind_next  = dcs_pkg::KIND_LISTED;
                    idx_next   = pend_idx_reg;
                    total_next = cnt_reg;
                end
                else
                begin
                    kind_next  = dcs_pkg::KIND_EMPTY;
                    idx_next   = '0;
                    total_next = '0;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            thr_reg      <= '0;
            wl_reg       <= dcs_pkg::WLEN_RESET;
            valid_reg    <= '0;
            fsp_reg      <= '0;
            hwm_reg      <= HW'(1);
            cnt_reg      <= '0;
            ctr_reg      <= '0;
            pos_reg      <= '0;
            j_reg        <= '0;
            k_reg        <= '0;
            matched_reg  <= 1'b0;
            s1_vld_reg   <= 1'b0;
            s1_last_reg  <= 1'b0;
            s2_vld_reg   <= 1'b0;
            s2_last_reg  <= 1'b0;
            dst_reg      <= '0;
            cpw_reg      <= 1'b0;
            pend_reg     <= 1'b0;
            done_reg     <= 1'b0;
            kind_reg     <= dcs_pkg::KIND_ACCEPTED;
            last_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            thr_reg      <= thr_next;
            wl_reg       <= wl_next;
            valid_reg    <= valid_next;
            fsp_reg      <= fsp_next;
            hwm_reg      <= hwm_next;
            cnt_reg      <= cnt_next;
            ctr_reg      <= ctr_next;
            pos_reg      <= pos_next;
            j_reg        <= j_next;
            k_reg        <= k_next;
            matched_reg  <= matched_next;
            s1_vld_reg   <= s1_vld_next;
            s1_last_reg  <= s1_last_next;
            s2_vld_reg   <= s2_vld_next;
            s2_last_reg  <= s2_last_next;
            dst_reg      <= dst_next;
            cpw_reg      <= cpw_next;
            pend_reg     <= pend_next;
            done_reg     <= done_next;
            kind_reg     <= kind_next;
            last_reg     <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg      <= acc_next;
        sq_reg       <= sq_next;
        cpk_reg      <= cpk_next;
        pend_idx_reg <= pend_idx_next;
        idx_reg      <= idx_next;
        total_reg    <= total_next;
    end

    always_ff @(posedge clk)
    begin
        if (win_we)
        begin
            win_mem[pos_reg] <= sample_value;
        end
        win_q <= win_mem[k_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cpw_reg)
        begin
            cand_mem[cand_waddr] <= win_q;
        end
        cand_q <= cand_mem[cand_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (start_we)
        begin
            start_mem[start_waddr] <= ctr_reg;
        end
        start_q <= start_mem[j_reg];
    end

    assign done            = done_reg;
    assign result_kind     = kind_reg;
    assign candidate_index = idx_reg;
    assign candidate_total = dcs_pkg::TOTAL_W'(total_reg);
    assign last_result     = last_reg;

    a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        32'($countones(valid_reg)) == 32'(cnt_reg))
        else $error("valid count differs from valid slots");

    a_count_below_hwm: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= hwm_reg)
        else $error("valid count above high-water mark");

    a_partial_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !mode && pos_more) |=> !done_reg)
        else $error("result on incomplete subsequence");

    a_only_listing_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && !last_reg) |-> (kind_reg == dcs_pkg::KIND_LISTED))
        else $error("non-final result outside readout");

    a_judged_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (kind_reg == dcs_pkg::KIND_ACCEPTED || kind_reg == dcs_pkg::KIND_REJECTED
            || kind_reg == dcs_pkg::KIND_OVERFLOW))
        |-> (ctr_reg == idx_reg + dcs_pkg::IDX_W'(1)))
        else $error("subsequence counter out of step");

endmodule
